>>> src/kcl_pkg.sv
// Package for the keypad code lock: request structs and fixed codes.
// Used by keypad_code_lock_top and its checker; depends on nothing.
package kcl_pkg;

  // Input action codes.
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Lock modes as shown on the result.
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_UNLOCKED = 2'd1;
  localparam logic [1:0] MODE_LOCKOUT  = 2'd2;

  // Feedback phases.
  localparam logic [2:0] PH_NONE     = 3'd0;
  localparam logic [2:0] PH_KEY      = 3'd1;
  localparam logic [2:0] PH_FAIL     = 3'd2;
  localparam logic [2:0] PH_UNLOCK   = 3'd3;
  localparam logic [2:0] PH_LOCK_ON  = 3'd4;
  localparam logic [2:0] PH_LOCK_OFF = 3'd5;

  // Indicator colors.
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_BLUE  = 2'd1;
  localparam logic [1:0] LED_RED   = 2'd2;
  localparam logic [1:0] LED_GREEN = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_CODE_DIGITS      = 3'd0;
  localparam logic [2:0] REG_FAIL_LIMIT       = 3'd1;
  localparam logic [2:0] REG_UNLOCK_TICKS     = 3'd2;
  localparam logic [2:0] REG_LOCKOUT_BLINKS   = 3'd3;
  localparam logic [2:0] REG_KEY_TICKS        = 3'd4;
  localparam logic [2:0] REG_FAIL_FLASH_TICKS = 3'd5;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef struct packed {
    logic       action;
    logic [3:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] led_color;
    logic       solenoid_open;
    logic [1:0] mode;
    logic       key_accepted;
    logic [3:0] failures;
  } out_item_t;

endpackage

>>> src/keypad_code_lock_top.sv
// Keypad code lock: digit buffer, code compare, failure count and feedback timers.
// Depends on kcl_pkg for the request structs and the mode, phase and color codes.
//
// Usage. The input channel (in_valid_i, in_stall_o, in_item_i) carries one request
// per event: a key press with its digit, or a time tick. Every request yields
// exactly one result on the output channel (out_valid_o, out_stall_i,
// out_item_o) that shows the lock state after that event.
// The result is registered: an accepted request's result goes to the result
// register, or to the skid register while the output stalls. Throughput is one
// request per cycle while in_stall_o is low; nothing in the block iterates.
// The result register is backed by a one-entry skid register, so the block
// keeps taking a request while a finished result waits on a stalled receiver.
// in_stall_o rises only when both are full and is driven from a register.
// The configuration port (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; writes to indexes beyond the last register are dropped.
// Reset clears the lock to idle with no digits, no failures and the default
// code and timings, and empties both result registers.
module keypad_code_lock_top #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  kcl_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output kcl_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CntW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CntW-1:0] LastPos = CntW'(CODE_LENGTH - 1);

  // Configuration registers.
  logic [15:0] code_digits_q;
  logic [3:0]  fail_limit_q;
  logic [7:0]  unlock_ticks_q;
  logic [3:0]  lockout_blinks_q;
  logic [3:0]  key_ticks_q;
  logic [3:0]  fail_flash_ticks_q;

  // Lock state.
  logic [1:0]      mode_q, mode_d;
  logic [3:0]      digits_q [CODE_LENGTH];
  logic [CntW-1:0] entry_cnt_q, entry_cnt_d;
  logic [3:0]      fail_cnt_q, fail_cnt_d;
  logic [7:0]      timer_q, timer_d;
  logic [2:0]      phase_q, phase_d;
  logic [3:0]      blink_cnt_q, blink_cnt_d;
  logic            key_store;
  logic            code_match;
  logic [3:0]      fail_inc;

  // Result registers.
  kcl_pkg::out_item_t res_d;
  kcl_pkg::out_item_t out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               in_fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_digits_q      <= 16'h4210;
      fail_limit_q       <= 4'd5;
      unlock_ticks_q     <= 8'd10;
      lockout_blinks_q   <= 4'd5;
      key_ticks_q        <= 4'd1;
      fail_flash_ticks_q <= 4'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kcl_pkg::REG_CODE_DIGITS:      code_digits_q      <= cfg_data_i;
        kcl_pkg::REG_FAIL_LIMIT:       fail_limit_q       <= cfg_data_i[3:0];
        kcl_pkg::REG_UNLOCK_TICKS:     unlock_ticks_q     <= cfg_data_i[7:0];
        kcl_pkg::REG_LOCKOUT_BLINKS:   lockout_blinks_q   <= cfg_data_i[3:0];
        kcl_pkg::REG_KEY_TICKS:        key_ticks_q        <= cfg_data_i[3:0];
        kcl_pkg::REG_FAIL_FLASH_TICKS: fail_flash_ticks_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // The completing digit is compared straight from the request; the earlier
  // ones come from the buffer. Expected digits past the fourth are zero.
  always_comb begin
    logic [3:0] got;
    logic [3:0] want;
    code_match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      got  = (i == CODE_LENGTH - 1) ? in_item_i.key_value : digits_q[i];
      want = (i < 4) ? code_digits_q[4*i +: 4] : 4'd0;
      if (got != want) begin
        code_match = 1'b0;
      end
    end
  end

  assign fail_inc = (fail_cnt_q < fail_limit_q) ? fail_cnt_q + 4'd1 : fail_cnt_q;

  always_comb begin
    mode_d      = mode_q;
    entry_cnt_d = entry_cnt_q;
    fail_cnt_d  = fail_cnt_q;
    timer_d     = timer_q;
    phase_d     = phase_q;
    blink_cnt_d = blink_cnt_q;
    key_store   = 1'b0;

    if (in_item_i.action == kcl_pkg::ACT_KEY) begin
      if (mode_q == kcl_pkg::MODE_IDLE && phase_q == kcl_pkg::PH_NONE) begin
        key_store = 1'b1;
        if (entry_cnt_q != LastPos) begin
          entry_cnt_d = entry_cnt_q + CntW'(1);
          phase_d     = (key_ticks_q == 4'd0) ? kcl_pkg::PH_NONE : kcl_pkg::PH_KEY;
          timer_d     = {4'd0, key_ticks_q};
        end else begin
          entry_cnt_d = '0;
          if (code_match) begin
            fail_cnt_d = 4'd0;
            mode_d     = kcl_pkg::MODE_UNLOCKED;
            phase_d    = kcl_pkg::PH_UNLOCK;
            timer_d    = unlock_ticks_q;
          end else begin
            fail_cnt_d = fail_inc;
            if (fail_inc >= fail_limit_q) begin
              mode_d      = kcl_pkg::MODE_LOCKOUT;
              phase_d     = kcl_pkg::PH_LOCK_ON;
              blink_cnt_d = lockout_blinks_q;
              timer_d     = 8'd0;
            end else begin
              phase_d = (fail_flash_ticks_q == 4'd0) ? kcl_pkg::PH_NONE
                                                     : kcl_pkg::PH_FAIL;
              timer_d = {4'd0, fail_flash_ticks_q};
            end
          end
        end
      end
    end else begin
      unique case (phase_q)
        kcl_pkg::PH_KEY, kcl_pkg::PH_FAIL, kcl_pkg::PH_UNLOCK: begin
          if (timer_q <= 8'd1) begin
            phase_d = kcl_pkg::PH_NONE;
            timer_d = 8'd0;
            if (phase_q == kcl_pkg::PH_UNLOCK) begin
              mode_d = kcl_pkg::MODE_IDLE;
            end
          end else begin
            timer_d = timer_q - 8'd1;
          end
        end
        kcl_pkg::PH_LOCK_ON: begin
          phase_d = kcl_pkg::PH_LOCK_OFF;
        end
        kcl_pkg::PH_LOCK_OFF: begin
          if (blink_cnt_q <= 4'd1) begin
            blink_cnt_d = 4'd0;
            mode_d      = kcl_pkg::MODE_IDLE;
            phase_d     = kcl_pkg::PH_NONE;
            timer_d     = 8'd0;
          end else begin
            blink_cnt_d = blink_cnt_q - 4'd1;
            phase_d     = kcl_pkg::PH_LOCK_ON;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (phase_d)
      kcl_pkg::PH_KEY:     res_d.led_color = kcl_pkg::LED_BLUE;
      kcl_pkg::PH_FAIL:    res_d.led_color = kcl_pkg::LED_RED;
      kcl_pkg::PH_UNLOCK:  res_d.led_color = kcl_pkg::LED_GREEN;
      kcl_pkg::PH_LOCK_ON: res_d.led_color = kcl_pkg::LED_RED;
      default:             res_d.led_color = kcl_pkg::LED_OFF;
    endcase
    res_d.solenoid_open = (mode_d == kcl_pkg::MODE_UNLOCKED);
    res_d.mode          = mode_d;
    res_d.key_accepted  = key_store;
    res_d.failures      = fail_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= kcl_pkg::MODE_IDLE;
      entry_cnt_q <= '0;
      fail_cnt_q  <= 4'd0;
      timer_q     <= 8'd0;
      phase_q     <= kcl_pkg::PH_NONE;
      blink_cnt_q <= 4'd0;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        digits_q[i] <= 4'd0;
      end
    end else if (in_fire) begin
      mode_d_check: begin
        mode_q      <= mode_d;
        entry_cnt_q <= entry_cnt_d;
        fail_cnt_q  <= fail_cnt_d;
        timer_q     <= timer_d;
        phase_q     <= phase_d;
        blink_cnt_q <= blink_cnt_d;
        if (key_store) begin
          digits_q[entry_cnt_q] <= in_item_i.key_value;
        end
      end
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

endmodule

>>> src/kcl_checker.sv
// Port-level checks for keypad_code_lock_top, bound to every instance of it.
// Depends on kcl_pkg for the result struct and the mode and color codes.
module kcl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input kcl_pkg::out_item_t out_item_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // The solenoid is open exactly while the lock reports unlocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_item_o.solenoid_open == (out_item_o.mode == kcl_pkg::MODE_UNLOCKED)))
    else $error("solenoid disagrees with mode");

  // Green shows if and only if the lock is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_item_o.led_color == kcl_pkg::LED_GREEN) ==
       (out_item_o.mode == kcl_pkg::MODE_UNLOCKED)))
    else $error("green light disagrees with mode");

  // A stored key that opens the lock comes with no failures: a correct code clears failures.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.key_accepted &&
      out_item_o.mode == kcl_pkg::MODE_UNLOCKED |-> out_item_o.failures == 4'd0)
    else $error("failures not cleared on unlock");

  // The input side stalls only while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
